FILE: sv/stkfr_pkg.sv
// Shared types and constants for the STK500v2 frame receiver.
`default_nettype none

package stkfr_pkg;

	localparam logic [7:0] START_BYTE = 8'd27;
	localparam logic [7:0] TOKEN_BYTE = 8'd14;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_SEQ  = 3'd1,
		PH_LENH = 3'd2,
		PH_LENL = 3'd3,
		PH_TOK  = 3'd4,
		PH_BODY = 3'd5,
		PH_CSUM = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_DATA = 2'd1,
		EV_GOOD = 2'd2,
		EV_BAD  = 2'd3
	} event_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} in_stage_t;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [7:0]  frame_sequence;
		logic [15:0] payload_index;
		logic [7:0]  payload_byte;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/stkfr_in_stage.sv
// Input register stage that holds one received byte until the deframer takes it.
`default_nettype none

module stkfr_in_stage
	import stkfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       advance,
	output in_stage_t       stage
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       accept;

	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_tdata;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = data_s1;

endmodule

`default_nettype wire

FILE: sv/stkfr_deframe.sv
// Frame state machine, checksum accumulation and result register.
`default_nettype none

module stkfr_deframe
	import stkfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire in_stage_t  stage,
	output logic            advance,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [47:0]     m_tdata,
	output logic [1:0]      m_tuser
);

	phase_t      phase_q, phase_d;
	logic [7:0]  seq_q, seq_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  b;
	logic [7:0]  xor_next;
	logic [15:0] count_inc;

	event_t      ev_d;
	result_t     res_d;
	logic        valid_s2;
	event_t      ev_s2;
	result_t     res_s2;

	assign b         = stage.data;
	assign xor_next  = xor_q ^ b;
	assign count_inc = count_q + 16'd1;
	assign advance   = stage.valid && (!valid_s2 || m_tready);

	always_comb begin
		phase_d = phase_q;
		seq_d   = seq_q;
		len_d   = len_q;
		count_d = count_q;
		xor_d   = xor_next;
		case (phase_q)
			PH_SEQ: begin
				seq_d   = b;
				phase_d = PH_LENH;
			end
			PH_LENH: begin
				len_d   = {b, 8'd0};
				phase_d = PH_LENL;
			end
			PH_LENL: begin
				len_d   = {len_q[15:8], b};
				phase_d = PH_TOK;
			end
			PH_TOK: begin
				if (b == TOKEN_BYTE) begin
					count_d = 16'd0;
					phase_d = (len_q == 16'd0) ? PH_CSUM : PH_BODY;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				count_d = count_inc;
				if (count_inc == len_q) begin
					phase_d = PH_CSUM;
				end
			end
			PH_CSUM: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = (b == START_BYTE) ? PH_SEQ : PH_HUNT;
				xor_d   = b;
			end
		endcase
	end

	always_comb begin
		ev_d  = EV_NONE;
		res_d = '0;
		case (phase_q)
			PH_BODY: begin
				ev_d                 = EV_DATA;
				res_d.payload_byte   = b;
				res_d.payload_index  = count_q;
				res_d.frame_sequence = seq_q;
				res_d.frame_length   = len_q;
			end
			PH_CSUM: begin
				ev_d                 = (xor_next == 8'd0) ? EV_GOOD : EV_BAD;
				res_d.frame_sequence = seq_q;
				res_d.frame_length   = len_q;
			end
			default: begin
				ev_d = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			seq_q    <= 8'd0;
			len_q    <= 16'd0;
			count_q  <= 16'd0;
			xor_q    <= 8'd0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				phase_q  <= phase_d;
				seq_q    <= seq_d;
				len_q    <= len_d;
				count_q  <= count_d;
				xor_q    <= xor_d;
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_s2  <= ev_d;
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = ev_s2;
	assign m_tdata  = res_s2;

endmodule

`default_nettype wire

FILE: sv/stk500v2_frame_receiver_core.sv
// Top level of the STK500v2 frame receiver: input stage, deframer and checks.
//
// Channel  Dir  Signals                      Content
// s_*      in   tvalid tready tdata[7:0]     rx_byte
// m_*      out  tvalid tready tdata tuser    one result per received byte
//
// Every received byte yields exactly one result transaction.
// A byte passes through the input register, then the result register after the
// frame state logic. One byte per cycle is sustained while m_tready is high.
// The asynchronous reset returns the receiver to hunting for a start byte.
// When the result register is full and not taken, the input stage holds one
// more byte and then drops tready.
`default_nettype none

module stk500v2_frame_receiver_core
	import stkfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
	                                    // [31:24] frame_sequence, [47:32] frame_length
	output logic [1:0]       m_tuser    // [1:0] event_kind
);

	in_stage_t stage;
	logic      advance;

	stkfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.stage    (stage)
	);

	stkfr_deframe u_deframe (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage    (stage),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_NONE) |-> (m_tdata == 48'd0))
		else $error("Empty result carries nonzero data.");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_DATA) |->
		(m_tdata[47:32] != 16'd0 && m_tdata[23:8] < m_tdata[47:32]))
		else $error("Payload index lies outside the declared length.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("Input stalled while the result register could drain.");
`endif

endmodule

`default_nettype wire
